// ===== rtl/sflq_pkg.sv =====
// Shared types, sizes and codes for the start/finish latency queue.
// No dependencies; used by every module of the block except sflq_ram.
`timescale 1ns / 1ps

package sflq_pkg;

  localparam int START_DEPTH  = 16;
  localparam int RESULT_DEPTH = 16;

  localparam int START_PTR_W  = $clog2(START_DEPTH);
  localparam int START_CNT_W  = $clog2(START_DEPTH + 1);
  localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);
  localparam int RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);

  localparam int ID_W     = 8;
  localparam int SECS_W   = 32;
  localparam int MILLIS_W = 10;

  localparam logic [MILLIS_W-1:0] MILLIS_PER_SEC = MILLIS_W'(1000);

  // request kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // result status codes
  localparam logic [2:0] STS_OK           = 3'd0;
  localparam logic [2:0] STS_START_FULL   = 3'd1;
  localparam logic [2:0] STS_START_EMPTY  = 3'd2;
  localparam logic [2:0] STS_RESULT_FULL  = 3'd3;
  localparam logic [2:0] STS_RESULT_EMPTY = 3'd4;

  // record source select
  localparam logic [1:0] REC_ZERO   = 2'd0;
  localparam logic [1:0] REC_START  = 2'd1;
  localparam logic [1:0] REC_FINISH = 2'd2;
  localparam logic [1:0] REC_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]          kind;
    logic [ID_W-1:0]     entry_id;
    logic [SECS_W-1:0]   time_seconds;
    logic [MILLIS_W-1:0] time_millis;
    logic                remove_flag;
  } sflq_req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [ID_W-1:0]         skier_id;
    logic [SECS_W-1:0]       start_seconds;
    logic [MILLIS_W-1:0]     start_millis;
    logic [SECS_W-1:0]       finish_seconds;
    logic [MILLIS_W-1:0]     finish_millis;
    logic                    removed;
    logic [SECS_W-1:0]       elapsed_seconds;
    logic [MILLIS_W-1:0]     elapsed_millis;
    logic [START_CNT_W-1:0]  on_course_count;
    logic [RESULT_CNT_W-1:0] stored_count;
  } sflq_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [SECS_W-1:0]   secs;
    logic [MILLIS_W-1:0] millis;
  } start_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic                removed;
    logic [SECS_W-1:0]   start_secs;
    logic [MILLIS_W-1:0] start_millis;
    logic [SECS_W-1:0]   finish_secs;
    logic [MILLIS_W-1:0] finish_millis;
    logic [SECS_W-1:0]   elapsed_secs;
    logic [MILLIS_W-1:0] elapsed_millis;
  } result_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_req;
    logic       exec;
    logic       push_start;
    logic       pop_start;
    logic       push_result;
    logic       pop_result;
    logic [2:0] status;
    logic [1:0] rec_sel;
  } sflq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] kind;
    logic       remove_flag;
    logic       start_full;
    logic       start_empty;
    logic       result_full;
    logic       result_empty;
  } sflq_sts_t;

endpackage

// ===== rtl/start_finish_latency_queue.sv =====
// Every request has an accept cycle, at whose closing edge the start-queue
// and result-FIFO RAMs capture the oldest entries in their registered read ports, and
// an execute cycle, in which the elapsed time is formed and the queues are
// updated. busy is high during the execute cycle only, so no new request is
// accepted while one executes. Each request yields exactly one result, shown on
// rsp_o with done_o high for a single cycle, starting the cycle after the execute
// cycle; the receiver cannot stall and must take it then. No clearing pass is
// needed after reset.
// Top level: joins sflq_ctrl and sflq_datapath. Depends on sflq_pkg.
`timescale 1ns / 1ps

module start_finish_latency_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  sflq_pkg::sflq_req_t req_i,
  output logic                done_o,
  output sflq_pkg::sflq_rsp_t rsp_o
);

  sflq_pkg::sflq_cmd_t cmd;
  sflq_pkg::sflq_sts_t sts;

  sflq_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .sts_i (sts),
    .busy_o(busy),
    .cmd_o (cmd)
  );

  sflq_datapath u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

`ifndef ASSERT_OFF
  // an accepted request is executed in the very next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request not executed");

  // a result strobe only follows an execute cycle
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without execute cycle");

  // no push into a full start queue
  a_no_start_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_start |-> !sts.start_full)
    else $error("push into full start queue");

  // a start entry leaves only on a finish that found one
  a_pop_start_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop_start |-> (sts.kind == sflq_pkg::KIND_FINISH) && !sts.start_empty)
    else $error("illegal start queue pop");
`endif

endmodule

// ===== rtl/sflq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sflq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/sflq_ctrl.sv =====
// Controller: accept handshake, two-state sequencer and per-request decisions.
// Depends on sflq_pkg.
`timescale 1ns / 1ps

module sflq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sflq_pkg::sflq_sts_t sts_i,
  output logic              busy_o,
  output sflq_pkg::sflq_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == ST_EXEC);

  always_comb begin
    cmd_o          = '0;
    cmd_o.status   = sflq_pkg::STS_OK;
    cmd_o.rec_sel  = sflq_pkg::REC_ZERO;
    cmd_o.load_req = start_i && (state_q == ST_IDLE);
    cmd_o.exec     = (state_q == ST_EXEC);
    if (state_q == ST_EXEC) begin
      unique case (sts_i.kind)
        sflq_pkg::KIND_START: begin
          cmd_o.rec_sel = sflq_pkg::REC_START;
          if (sts_i.start_full) begin
            cmd_o.status = sflq_pkg::STS_START_FULL;
          end else begin
            cmd_o.push_start = 1'b1;
          end
        end
        sflq_pkg::KIND_FINISH: begin
          if (sts_i.start_empty) begin
            cmd_o.status = sflq_pkg::STS_START_EMPTY;
          end else begin
            cmd_o.rec_sel   = sflq_pkg::REC_FINISH;
            cmd_o.pop_start = sts_i.remove_flag;
            // record still reported when the result FIFO is full
            if (sts_i.result_full) begin
              cmd_o.status = sflq_pkg::STS_RESULT_FULL;
            end else begin
              cmd_o.push_result = 1'b1;
            end
          end
        end
        sflq_pkg::KIND_READ: begin
          if (sts_i.result_empty) begin
            cmd_o.status = sflq_pkg::STS_RESULT_EMPTY;
          end else begin
            cmd_o.rec_sel    = sflq_pkg::REC_READ;
            cmd_o.pop_result = 1'b1;
          end
        end
        default: cmd_o.rec_sel = sflq_pkg::REC_ZERO;
      endcase
    end
  end

endmodule

// ===== rtl/sflq_datapath.sv =====
// Datapath: request register, start queue and result FIFO with their pointers,
// elapsed-time arithmetic and result register. Depends on sflq_pkg, sflq_ram.
`timescale 1ns / 1ps

module sflq_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sflq_pkg::sflq_req_t req_i,
  input  sflq_pkg::sflq_cmd_t cmd_i,
  output sflq_pkg::sflq_sts_t sts_o,
  output logic                done_o,
  output sflq_pkg::sflq_rsp_t rsp_o
);

  localparam int SPW = sflq_pkg::START_PTR_W;
  localparam int SCW = sflq_pkg::START_CNT_W;
  localparam int RPW = sflq_pkg::RESULT_PTR_W;
  localparam int RCW = sflq_pkg::RESULT_CNT_W;
  localparam int MW  = sflq_pkg::MILLIS_W;
  localparam int SW  = sflq_pkg::SECS_W;

  localparam logic [SPW-1:0] START_LAST  = SPW'(sflq_pkg::START_DEPTH - 1);
  localparam logic [RPW-1:0] RESULT_LAST = RPW'(sflq_pkg::RESULT_DEPTH - 1);
  localparam logic [SCW-1:0] START_FULL  = SCW'(sflq_pkg::START_DEPTH);
  localparam logic [RCW-1:0] RESULT_FULL = RCW'(sflq_pkg::RESULT_DEPTH);

  sflq_pkg::sflq_req_t req_q;

  logic [SPW-1:0] start_wr_q, start_wr_d, start_rd_q, start_rd_d;
  logic [SCW-1:0] start_cnt_q, start_cnt_d;
  logic [RPW-1:0] res_head_q, res_head_d, res_tail_q, res_tail_d;
  logic [RCW-1:0] res_cnt_q, res_cnt_d;

  sflq_pkg::start_entry_t  start_wdata, start_rdata;
  sflq_pkg::result_entry_t res_wdata, res_rdata;

  logic          done_q;
  sflq_pkg::sflq_rsp_t rsp_q, rsp_d;

  logic [MW:0]   ms_diff;
  logic          borrow;
  logic [SW-1:0] el_secs;
  logic [MW-1:0] el_millis;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
  end

  assign start_wdata.id     = req_q.entry_id;
  assign start_wdata.secs   = req_q.time_seconds;
  assign start_wdata.millis = req_q.time_millis;

  // read address is the current oldest entry; data lands at the accept edge
  sflq_ram #(
    .Width($bits(sflq_pkg::start_entry_t)),
    .Depth(sflq_pkg::START_DEPTH)
  ) u_start_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push_start),
    .waddr_i(start_wr_q),
    .wdata_i(start_wdata),
    .raddr_i(start_rd_q),
    .rdata_o(start_rdata)
  );

  // millis difference is one bit wider; its top bit flags a borrow
  assign ms_diff   = {1'b0, req_q.time_millis} - {1'b0, start_rdata.millis};
  assign borrow    = ms_diff[MW];
  assign el_secs   = req_q.time_seconds - start_rdata.secs - SW'(borrow);
  assign el_millis = borrow ? (ms_diff[MW-1:0] + sflq_pkg::MILLIS_PER_SEC)
                            : ms_diff[MW-1:0];

  assign res_wdata.id             = start_rdata.id;
  assign res_wdata.removed        = req_q.remove_flag;
  assign res_wdata.start_secs     = start_rdata.secs;
  assign res_wdata.start_millis   = start_rdata.millis;
  assign res_wdata.finish_secs    = req_q.time_seconds;
  assign res_wdata.finish_millis  = req_q.time_millis;
  assign res_wdata.elapsed_secs   = el_secs;
  assign res_wdata.elapsed_millis = el_millis;

  sflq_ram #(
    .Width($bits(sflq_pkg::result_entry_t)),
    .Depth(sflq_pkg::RESULT_DEPTH)
  ) u_result_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push_result),
    .waddr_i(res_tail_q),
    .wdata_i(res_wdata),
    .raddr_i(res_head_q),
    .rdata_o(res_rdata)
  );

  always_comb begin
    start_wr_d  = start_wr_q;
    start_rd_d  = start_rd_q;
    start_cnt_d = start_cnt_q;
    res_head_d  = res_head_q;
    res_tail_d  = res_tail_q;
    res_cnt_d   = res_cnt_q;
    if (cmd_i.push_start) begin
      start_wr_d  = (start_wr_q == START_LAST) ? '0 : start_wr_q + SPW'(1);
      start_cnt_d = start_cnt_q + SCW'(1);
    end
    if (cmd_i.pop_start) begin
      start_rd_d  = (start_rd_q == START_LAST) ? '0 : start_rd_q + SPW'(1);
      start_cnt_d = start_cnt_q - SCW'(1);
    end
    if (cmd_i.push_result) begin
      res_tail_d = (res_tail_q == RESULT_LAST) ? '0 : res_tail_q + RPW'(1);
      res_cnt_d  = res_cnt_q + RCW'(1);
    end
    if (cmd_i.pop_result) begin
      res_head_d = (res_head_q == RESULT_LAST) ? '0 : res_head_q + RPW'(1);
      res_cnt_d  = res_cnt_q - RCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_wr_q  <= '0;
      start_rd_q  <= '0;
      start_cnt_q <= '0;
      res_head_q  <= '0;
      res_tail_q  <= '0;
      res_cnt_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      start_wr_q  <= start_wr_d;
      start_rd_q  <= start_rd_d;
      start_cnt_q <= start_cnt_d;
      res_head_q  <= res_head_d;
      res_tail_q  <= res_tail_d;
      res_cnt_q   <= res_cnt_d;
      done_q      <= cmd_i.exec;
    end
  end

  always_comb begin
    rsp_d        = '0;
    rsp_d.status = cmd_i.status;
    case (cmd_i.rec_sel)
      sflq_pkg::REC_START: begin
        rsp_d.skier_id      = req_q.entry_id;
        rsp_d.start_seconds = req_q.time_seconds;
        rsp_d.start_millis  = req_q.time_millis;
      end
      sflq_pkg::REC_FINISH: begin
        rsp_d.skier_id        = res_wdata.id;
        rsp_d.start_seconds   = res_wdata.start_secs;
        rsp_d.start_millis    = res_wdata.start_millis;
        rsp_d.finish_seconds  = res_wdata.finish_secs;
        rsp_d.finish_millis   = res_wdata.finish_millis;
        rsp_d.removed         = res_wdata.removed;
        rsp_d.elapsed_seconds = res_wdata.elapsed_secs;
        rsp_d.elapsed_millis  = res_wdata.elapsed_millis;
      end
      sflq_pkg::REC_READ: begin
        rsp_d.skier_id        = res_rdata.id;
        rsp_d.start_seconds   = res_rdata.start_secs;
        rsp_d.start_millis    = res_rdata.start_millis;
        rsp_d.finish_seconds  = res_rdata.finish_secs;
        rsp_d.finish_millis   = res_rdata.finish_millis;
        rsp_d.removed         = res_rdata.removed;
        rsp_d.elapsed_seconds = res_rdata.elapsed_secs;
        rsp_d.elapsed_millis  = res_rdata.elapsed_millis;
      end
      default: rsp_d.skier_id = '0;
    endcase
    rsp_d.on_course_count = start_cnt_d;
    rsp_d.stored_count    = res_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign sts_o.kind         = req_q.kind;
  assign sts_o.remove_flag  = req_q.remove_flag;
  assign sts_o.start_full   = (start_cnt_q == START_FULL);
  assign sts_o.start_empty  = (start_cnt_q == '0);
  assign sts_o.result_full  = (res_cnt_q == RESULT_FULL);
  assign sts_o.result_empty = (res_cnt_q == '0);

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for start_finish_latency_queue: start/finish/read requests,
// predicted results and a per-field check of every done_o strobe.
// Depends on sflq_pkg and the start_finish_latency_queue RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int MW  = sflq_pkg::MILLIS_W;
  localparam int SCW = sflq_pkg::START_CNT_W;
  localparam int RCW = sflq_pkg::RESULT_CNT_W;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} traffic_e;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  sflq_pkg::sflq_req_t req;
  logic                done_o;
  sflq_pkg::sflq_rsp_t rsp;

  // predictor state
  sflq_pkg::start_entry_t  course_mem [sflq_pkg::START_DEPTH];
  int                      course_wr, course_rd, course_cnt;
  sflq_pkg::result_entry_t record_mem [sflq_pkg::RESULT_DEPTH];
  int                      record_head, record_tail, record_cnt;

  sflq_pkg::sflq_rsp_t pending_records [$];
  sflq_pkg::sflq_rsp_t want;
  int                  err_count;
  int                  idle_cycles;
  bit                  no_idle;
  logic [31:0]         race_clock;

  start_finish_latency_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .rsp_o  (rsp)
  );

  always #5 clk_i = ~clk_i;

  function automatic sflq_pkg::sflq_rsp_t predict_event(input sflq_pkg::sflq_req_t r);
    sflq_pkg::sflq_rsp_t     o;
    sflq_pkg::start_entry_t  s;
    sflq_pkg::result_entry_t rec;
    int                      diff;
    o = '0;
    case (r.kind)
      sflq_pkg::KIND_START: begin
        o.skier_id      = r.entry_id;
        o.start_seconds = r.time_seconds;
        o.start_millis  = r.time_millis;
        if (course_cnt >= sflq_pkg::START_DEPTH) begin
          o.status = sflq_pkg::STS_START_FULL;
        end else begin
          course_mem[course_wr].id     = r.entry_id;
          course_mem[course_wr].secs   = r.time_seconds;
          course_mem[course_wr].millis = r.time_millis;
          course_wr = (course_wr + 1) % sflq_pkg::START_DEPTH;
          course_cnt++;
        end
      end
      sflq_pkg::KIND_FINISH: begin
        if (course_cnt == 0) begin
          o.status = sflq_pkg::STS_START_EMPTY;
        end else begin
          s = course_mem[course_rd];
          rec.id            = s.id;
          rec.removed       = r.remove_flag;
          rec.start_secs    = s.secs;
          rec.start_millis  = s.millis;
          rec.finish_secs   = r.time_seconds;
          rec.finish_millis = r.time_millis;
          rec.elapsed_secs  = r.time_seconds - s.secs;
          diff = int'(r.time_millis) - int'(s.millis);
          // borrow once; out-of-range millis can stay negative and wrap to 10 bits
          if (diff < 0) begin
            rec.elapsed_secs = rec.elapsed_secs - 32'd1;
            diff = diff + int'(sflq_pkg::MILLIS_PER_SEC);
          end
          rec.elapsed_millis = MW'(diff);
          if (r.remove_flag) begin
            course_rd = (course_rd + 1) % sflq_pkg::START_DEPTH;
            course_cnt--;
          end
          if (record_cnt >= sflq_pkg::RESULT_DEPTH) begin
            o.status = sflq_pkg::STS_RESULT_FULL;
          end else begin
            record_mem[record_tail] = rec;
            record_tail = (record_tail + 1) % sflq_pkg::RESULT_DEPTH;
            record_cnt++;
          end
          o.skier_id        = rec.id;
          o.start_seconds   = rec.start_secs;
          o.start_millis    = rec.start_millis;
          o.finish_seconds  = rec.finish_secs;
          o.finish_millis   = rec.finish_millis;
          o.removed         = rec.removed;
          o.elapsed_seconds = rec.elapsed_secs;
          o.elapsed_millis  = rec.elapsed_millis;
        end
      end
      sflq_pkg::KIND_READ: begin
        if (record_cnt == 0) begin
          o.status = sflq_pkg::STS_RESULT_EMPTY;
        end else begin
          rec = record_mem[record_head];
          o.skier_id        = rec.id;
          o.start_seconds   = rec.start_secs;
          o.start_millis    = rec.start_millis;
          o.finish_seconds  = rec.finish_secs;
          o.finish_millis   = rec.finish_millis;
          o.removed         = rec.removed;
          o.elapsed_seconds = rec.elapsed_secs;
          o.elapsed_millis  = rec.elapsed_millis;
          record_head = (record_head + 1) % sflq_pkg::RESULT_DEPTH;
          record_cnt--;
        end
      end
      default: ;
    endcase
    o.on_course_count = SCW'(course_cnt);
    o.stored_count    = RCW'(record_cnt);
    return o;
  endfunction

  function automatic sflq_pkg::sflq_req_t mk(input logic [1:0] kind, input logic [7:0] id,
                                             input logic [31:0] secs,
                                             input logic [9:0] millis, input logic rem);
    sflq_pkg::sflq_req_t r;
    r.kind         = kind;
    r.entry_id     = id;
    r.time_seconds = secs;
    r.time_millis  = millis;
    r.remove_flag  = rem;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request: hold start until accepted, predict, then drop start and idle
  task automatic send_event(input sflq_pkg::sflq_req_t r);
    @(negedge clk_i);
    start = 1'b1;
    req   = r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_records.push_back(predict_event(r));
    @(negedge clk_i);
    start = 1'b0;
    repeat (pick_gap()) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_records.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      err_count++;
      if (err_count <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_records.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result: %h", rsp);
      end else begin
        want = pending_records.pop_front();
        check_field("status", 32'(want.status), 32'(rsp.status));
        check_field("skier_id", 32'(want.skier_id), 32'(rsp.skier_id));
        check_field("start_seconds", want.start_seconds, rsp.start_seconds);
        check_field("start_millis", 32'(want.start_millis), 32'(rsp.start_millis));
        check_field("finish_seconds", want.finish_seconds, rsp.finish_seconds);
        check_field("finish_millis", 32'(want.finish_millis), 32'(rsp.finish_millis));
        check_field("removed", 32'(want.removed), 32'(rsp.removed));
        check_field("elapsed_seconds", want.elapsed_seconds, rsp.elapsed_seconds);
        check_field("elapsed_millis", 32'(want.elapsed_millis), 32'(rsp.elapsed_millis));
        check_field("on_course_count", 32'(want.on_course_count),
                    32'(rsp.on_course_count));
        check_field("stored_count", 32'(want.stored_count), 32'(rsp.stored_count));
      end
    end
  end

  // watchdog: cycles with neither an accepted request nor a result
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("start_finish_latency_queue verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_and_unused();
    send_event(mk(sflq_pkg::KIND_READ, 8'h00, 32'h0, 10'd0, 1'b0));
    send_event(mk(sflq_pkg::KIND_FINISH, 8'hff, 32'hffff_ffff, 10'd999, 1'b1));
    send_event(mk(KIND_UNUSED, 8'hff, 32'hffff_ffff, 10'h3ff, 1'b1));
  endtask

  task automatic test_extremes_and_borrow();
    send_event(mk(sflq_pkg::KIND_START, 8'h00, 32'h0, 10'd0, 1'b1));
    send_event(mk(sflq_pkg::KIND_START, 8'hff, 32'hffff_ffff, 10'd999, 1'b0));
    send_event(mk(sflq_pkg::KIND_START, 8'ha5, 32'd100, 10'h3ff, 1'b0));
    send_event(mk(sflq_pkg::KIND_FINISH, 8'h00, 32'd5, 10'd0, 1'b0));    // no borrow, kept
    send_event(mk(sflq_pkg::KIND_FINISH, 8'h00, 32'h0, 10'd999, 1'b1));  // removed
    send_event(mk(sflq_pkg::KIND_FINISH, 8'h5a, 32'h0, 10'd0, 1'b1));    // borrow, seconds wrap
    send_event(mk(sflq_pkg::KIND_FINISH, 8'h00, 32'd100, 10'd0, 1'b0));  // still negative after borrow
    send_event(mk(sflq_pkg::KIND_FINISH, 8'h00, 32'd200, 10'h3ff, 1'b1));
    send_event(mk(sflq_pkg::KIND_START, 8'h5a, 32'haaaa_aaaa, 10'h155, 1'b0));
    send_event(mk(sflq_pkg::KIND_FINISH, 8'h00, 32'h5555_5555, 10'h2aa, 1'b1));
    repeat (7) send_event(mk(sflq_pkg::KIND_READ, 8'h00, 32'h0, 10'd0, 1'b0));
    wait_drained();
  endtask

  // overflow both queues, then drain them to empty
  task automatic test_queue_limits();
    int i;
    for (i = 0; i <= sflq_pkg::START_DEPTH; i++)
      send_event(mk(sflq_pkg::KIND_START, 8'($urandom), $urandom,
                    10'($urandom_range(0, 999)), 1'($urandom)));
    for (i = 0; i <= sflq_pkg::RESULT_DEPTH; i++)
      send_event(mk(sflq_pkg::KIND_FINISH, 8'($urandom), $urandom,
                    10'($urandom_range(0, 999)), i == sflq_pkg::RESULT_DEPTH));
    wait_drained();
    for (i = 0; i <= sflq_pkg::RESULT_DEPTH; i++)
      send_event(mk(sflq_pkg::KIND_READ, 8'($urandom), $urandom,
                    10'($urandom_range(0, 999)), 1'($urandom)));
    for (i = 0; i < sflq_pkg::START_DEPTH; i++)
      send_event(mk(sflq_pkg::KIND_FINISH, 8'($urandom), $urandom,
                    10'($urandom_range(0, 999)), 1'b1));
    wait_drained();
  endtask

  function automatic sflq_pkg::sflq_req_t make_random(input traffic_e phase);
    sflq_pkg::sflq_req_t r;
    int                  pick, p_start, p_keep, p_rm;
    r.entry_id     = 8'($urandom);
    r.remove_flag  = 1'($urandom);
    r.time_seconds = race_clock;
    r.time_millis  = 10'($urandom_range(0, 999));
    case (phase)
      PH_FILL:  begin p_start = 60; p_keep = 25; p_rm = 5;  end
      PH_DRAIN: begin p_start = 15; p_keep = 10; p_rm = 35; end
      default:  begin p_start = 33; p_keep = 7;  p_rm = 25; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < p_start) begin
      r.kind = sflq_pkg::KIND_START;
      race_clock = race_clock + $urandom_range(0, 3);
    end else if (pick < p_start + p_keep + p_rm) begin
      r.kind        = sflq_pkg::KIND_FINISH;
      r.remove_flag = (pick >= p_start + p_keep);
      if (course_cnt > 0)
        r.time_seconds = course_mem[course_rd].secs + $urandom_range(0, 300);
    end else begin
      r.kind = sflq_pkg::KIND_READ;
    end
    if ($urandom_range(0, 99) < 15) begin
      r.time_seconds = $urandom;
      r.time_millis  = 10'($urandom_range(0, 1023));
    end
    return r;
  endfunction

  task automatic test_random_traffic();
    int       sent, len, k;
    traffic_e phase;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase      = traffic_e'($urandom_range(0, 2));
      len        = $urandom_range(10, 60);
      no_idle    = ($urandom_range(0, 3) == 0);
      race_clock = ($urandom_range(0, 3) == 0) ? 32'hffff_ff80 : $urandom;
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 3) begin
          send_event(mk(KIND_UNUSED, 8'($urandom), $urandom, 10'($urandom),
                        1'($urandom)));
        end else begin
          send_event(make_random(phase));
          sent++;
        end
      end
      if ($urandom_range(0, 4) == 0) wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req         = '0;
    err_count   = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    race_clock  = '0;
    course_wr   = 0;
    course_rd   = 0;
    course_cnt  = 0;
    record_head = 0;
    record_tail = 0;
    record_cnt  = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_and_unused();
    test_extremes_and_borrow();
    test_queue_limits();
    test_random_traffic();

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (err_count == 0 && pending_records.size() == 0) begin
      $display("start_finish_latency_queue verification clean");
    end else begin
      $display("start_finish_latency_queue verification failed");
    end
    $finish;
  end

endmodule
